@@ rtl/sopm_pkg.sv @@
// Shared types, codes and defaults for the signed opinion matrix update core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package sopm_pkg;

  localparam int MAX_AGENTS_DEFAULT = 64;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] REG_AGENT_COUNT    = 2'd0;
  localparam logic [1:0] REG_SPLIT_SIZE     = 2'd1;
  localparam logic [1:0] REG_START_SETTING  = 2'd2;
  localparam logic [1:0] REG_CHECK_INTERVAL = 2'd3;

  localparam logic [1:0] START_ROW0_COL1 = 2'd0;
  localparam logic [1:0] START_LAST_PREV = 2'd1;
  localparam logic [1:0] START_ROW0_LAST = 2'd2;

  typedef enum logic [2:0] {
    OUT_ONE_FACTION = 3'd0,
    OUT_UNCHANGED   = 3'd1,
    OUT_WIDENED     = 3'd2,
    OUT_NARROWED    = 3'd3,
    OUT_NONE        = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_ROW,
    S_STEP_BDR,
    S_STEP_RUN,
    S_CHK_LATI,
    S_CHK_RUN,
    S_CNT_RUN,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [6:0]  agent_count;
    logic [6:0]  split_size;
    logic [1:0]  start_setting;
    logic [15:0] check_interval;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [5:0] donor;
    logic [5:0] recipient;
  } request_t;

  typedef struct packed {
    logic              checked;
    logic              balanced;
    logic [2:0]        outcome;
    logic signed [7:0] faction_difference;
    logic [31:0]       step_count;
  } result_t;

endpackage

@@ rtl/sopm_mem.sv @@
// Sign matrix row memory: one write port, one registered read port.
// Per-row valid bits make unwritten rows read as all positive after reset.
`timescale 1ns / 1ps

module sopm_mem #(
  parameter int ROWS  = sopm_pkg::MAX_AGENTS_DEFAULT,
  parameter int WIDTH = sopm_pkg::MAX_AGENTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(ROWS)-1:0]  waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(ROWS)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [ROWS];
  logic [ROWS-1:0]  valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

@@ rtl/sopm_seq.sv @@
// Request sequencer and row datapath: init sweep, column rewrite, balance
// check and row-0 count. Uses sopm_pkg; drives the sopm_mem ports.
`timescale 1ns / 1ps

module sopm_seq #(
  parameter int MAX_AGENTS = sopm_pkg::MAX_AGENTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sopm_pkg::cfg_t                cfg,
  input  logic                          start,
  input  sopm_pkg::request_t            request,
  output logic                          busy,
  output logic                          done,
  output sopm_pkg::result_t             result,
  output logic                          mem_we,
  output logic [$clog2(MAX_AGENTS)-1:0] mem_waddr,
  output logic [MAX_AGENTS-1:0]         mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(MAX_AGENTS)-1:0] mem_raddr,
  input  logic [MAX_AGENTS-1:0]         mem_rdata
);

  localparam int AW = $clog2(MAX_AGENTS);
  localparam int NW = $clog2(MAX_AGENTS + 1);
  localparam int DW = NW + 2;
  localparam logic signed [DW-1:0] TWO = DW'(2);

  sopm_pkg::state_t state, state_next;

  logic [31:0]          ac32, n_full, sp32;
  logic [NW-1:0]        n, a, a_row0;
  logic [15:0]          interval;
  logic [AW-1:0]        last, n_less2, fr, fc;
  logic [AW-1:0]        d_in, r_in;
  logic [MAX_AGENTS-1:0] lt_a, lt_n, init_row, step_row, want;
  logic                 accept, col_bit, mismatch;

  logic [AW-1:0]         row, col, d, r;
  logic [NW-1:0]         pos;
  logic [MAX_AGENTS-1:0] rowi;
  logic                  bdr;
  logic                  finished, do_check, checked_flag, bal_flag;
  logic [31:0]           steps;
  logic [15:0]           countdown;
  logic signed [DW-1:0]  start_diff, cd, ac, ao, sd_now;
  logic [2:0]            outcome_calc;

  // effective configuration
  always_comb begin
    ac32 = 32'(cfg.agent_count);
    if (ac32 < 32'd4) begin
      n_full = 32'd4;
    end else if (ac32 > 32'(MAX_AGENTS)) begin
      n_full = 32'(MAX_AGENTS);
    end else begin
      n_full = ac32;
    end
    n    = NW'(n_full & ~32'd1);
    sp32 = 32'(cfg.split_size);
    a    = NW'((sp32 > 32'(n)) ? 32'(n) : sp32);
    // with an empty first faction, row 0 sees every agent as positive
    a_row0   = (a == '0) ? n : a;
    interval = (cfg.check_interval == 16'd0) ? 16'd1 : cfg.check_interval;
    last     = AW'(n - NW'(1));
    n_less2  = AW'(n - NW'(2));
    d_in = (32'(request.donor) >= 32'(n)) ? last : AW'(request.donor);
    r_in = (32'(request.recipient) >= 32'(n)) ? last : AW'(request.recipient);
    for (int j = 0; j < MAX_AGENTS; j++) begin
      lt_a[j] = NW'(j) < a;
      lt_n[j] = NW'(j) < n;
    end
    case (cfg.start_setting)
      sopm_pkg::START_ROW0_COL1: begin fr = '0;   fc = AW'(1); end
      sopm_pkg::START_LAST_PREV: begin fr = last; fc = n_less2; end
      sopm_pkg::START_ROW0_LAST: begin fr = '0;   fc = last;   end
      default:                   begin fr = last; fc = '0;     end
    endcase
  end

  // row datapath
  always_comb begin
    if (NW'(row) >= n) begin
      init_row = '0;
    end else begin
      init_row = ((NW'(row) < a) ? ~lt_a : lt_a) & lt_n;
    end
    if (row == fr) begin
      init_row = init_row ^ (MAX_AGENTS'(1) << fc);
    end
    col_bit  = (!mem_rdata[d] && !bdr && mem_rdata[r]) ? 1'b0 : (bdr ^ mem_rdata[r]);
    step_row = mem_rdata;
    step_row[d] = col_bit;
    want     = rowi[col] ? lt_n : '0;
    mismatch = ((rowi ^ mem_rdata) & lt_n) != want;
  end

  // row-0 difference and classification
  always_comb begin
    cd     = $signed({2'b00, n}) - $signed({1'b0, pos, 1'b0});
    ac     = cd[DW-1] ? -cd : cd;
    sd_now = start_diff;
    ao     = sd_now[DW-1] ? -sd_now : sd_now;
    if (cd == start_diff) begin
      outcome_calc = sopm_pkg::OUT_UNCHANGED;
    end else if (ac == $signed({2'b00, n})) begin
      outcome_calc = sopm_pkg::OUT_ONE_FACTION;
    end else if (ac == ao + TWO) begin
      outcome_calc = sopm_pkg::OUT_WIDENED;
    end else if (ac == ao - TWO) begin
      outcome_calc = sopm_pkg::OUT_NARROWED;
    end else begin
      outcome_calc = sopm_pkg::OUT_NONE;
    end
  end

  assign accept = start && (state == sopm_pkg::S_IDLE);
  assign busy   = state != sopm_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sopm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = row;
    mem_wdata  = init_row;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    case (state)
      sopm_pkg::S_IDLE: begin
        if (accept) begin
          if (request.operation == sopm_pkg::OP_INIT) begin
            state_next = sopm_pkg::S_INIT_ROW;
          end else if (finished) begin
            mem_re     = 1'b1;
            state_next = sopm_pkg::S_CNT_RUN;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = d_in;
            state_next = sopm_pkg::S_STEP_BDR;
          end
        end
      end
      sopm_pkg::S_INIT_ROW: begin
        mem_we = 1'b1;
        if (row == AW'(MAX_AGENTS - 1)) begin
          mem_re     = 1'b1;
          state_next = sopm_pkg::S_CNT_RUN;
        end
      end
      sopm_pkg::S_STEP_BDR: begin
        mem_re     = 1'b1;
        state_next = sopm_pkg::S_STEP_RUN;
      end
      sopm_pkg::S_STEP_RUN: begin
        mem_we    = 1'b1;
        mem_wdata = step_row;
        mem_re    = 1'b1;
        if (row == last) begin
          state_next = do_check ? sopm_pkg::S_CHK_LATI : sopm_pkg::S_CNT_RUN;
        end else begin
          mem_raddr = row + AW'(1);
        end
      end
      sopm_pkg::S_CHK_LATI: begin
        mem_re     = 1'b1;
        state_next = sopm_pkg::S_CHK_RUN;
      end
      sopm_pkg::S_CHK_RUN: begin
        mem_re = 1'b1;
        if (mismatch) begin
          state_next = sopm_pkg::S_CNT_RUN;
        end else if (col == last) begin
          if (row == last) begin
            state_next = sopm_pkg::S_CNT_RUN;
          end else begin
            mem_raddr  = row + AW'(1);
            state_next = sopm_pkg::S_CHK_LATI;
          end
        end else begin
          mem_raddr = col + AW'(1);
        end
      end
      sopm_pkg::S_CNT_RUN: begin
        if (col == last) begin
          state_next = sopm_pkg::S_REPORT;
        end
      end
      sopm_pkg::S_REPORT: begin
        state_next = sopm_pkg::S_IDLE;
      end
      default: begin
        state_next = sopm_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      finished     <= 1'b0;
      do_check     <= 1'b0;
      checked_flag <= 1'b0;
      bal_flag     <= 1'b0;
      steps        <= '0;
      countdown    <= '0;
      start_diff   <= '0;
    end else begin
      done <= state == sopm_pkg::S_REPORT;
      if (accept) begin
        if (request.operation == sopm_pkg::OP_INIT) begin
          steps        <= '0;
          countdown    <= interval;
          finished     <= 1'b0;
          start_diff   <= $signed({2'b00, n}) - $signed({1'b0, a_row0, 1'b0});
          checked_flag <= 1'b0;
          bal_flag     <= 1'b0;
        end else if (finished) begin
          checked_flag <= 1'b1;
          bal_flag     <= 1'b1;
        end else begin
          if (steps != 32'hFFFF_FFFF) begin
            steps <= steps + 32'd1;
          end
          if (countdown <= 16'd1) begin
            countdown    <= interval;
            do_check     <= 1'b1;
            checked_flag <= 1'b1;
          end else begin
            countdown    <= countdown - 16'd1;
            do_check     <= 1'b0;
            checked_flag <= 1'b0;
          end
          bal_flag <= 1'b0;
        end
      end
      if (state == sopm_pkg::S_CHK_RUN && !mismatch && col == last && row == last) begin
        bal_flag <= 1'b1;
        finished <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      sopm_pkg::S_IDLE: begin
        row <= '0;
        col <= '0;
        pos <= '0;
        d   <= d_in;
        r   <= r_in;
      end
      sopm_pkg::S_INIT_ROW: begin
        row <= row + AW'(1);
      end
      sopm_pkg::S_STEP_BDR: begin
        bdr <= mem_rdata[r];
      end
      sopm_pkg::S_STEP_RUN: begin
        row <= (row == last) ? '0 : row + AW'(1);
      end
      sopm_pkg::S_CHK_LATI: begin
        rowi <= mem_rdata;
        col  <= '0;
      end
      sopm_pkg::S_CHK_RUN: begin
        if (mismatch || (col == last && row == last)) begin
          col <= '0;
        end else if (col == last) begin
          row <= row + AW'(1);
        end else begin
          col <= col + AW'(1);
        end
      end
      sopm_pkg::S_CNT_RUN: begin
        pos <= pos + NW'(!mem_rdata[col]);
        col <= col + AW'(1);
      end
      sopm_pkg::S_REPORT: begin
        result.checked            <= checked_flag;
        result.balanced           <= bal_flag;
        result.outcome            <= bal_flag ? outcome_calc : sopm_pkg::OUT_NONE;
        result.faction_difference <= 8'(cd);
        result.step_count         <= steps;
      end
      default: begin
        row <= row;
      end
    endcase
  end

endmodule

@@ rtl/signed_opinion_matrix_update_core.sv @@
// Top level of the signed opinion matrix update core: configuration
// registers, sequencer and row memory. Uses sopm_pkg, sopm_seq, sopm_mem.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done and cannot be held off, so capture it then.
// An init request writes all MAX_AGENTS rows (one row written per cycle,
// then row 0 counted one bit per cycle). A step does one read-modify-write
// of each row through the single read port, then the row-0 count; a step
// that runs a balance check compares every row pair when balanced, and
// stops at the first unbalanced row pair it finds. A step after a balanced
// check only counts row 0. Busy may drop in the cycle done is high, and a
// new request may be taken in that cycle.

module signed_opinion_matrix_update_core #(
  parameter int MAX_AGENTS = sopm_pkg::MAX_AGENTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sopm_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output sopm_pkg::result_t  result,
  input  logic               write_enable,
  input  logic [1:0]         write_index,
  input  logic [15:0]        write_data
);

  localparam int AW = $clog2(MAX_AGENTS);

  sopm_pkg::cfg_t        cfg;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [MAX_AGENTS-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.agent_count    <= 7'd64;
      cfg.split_size     <= 7'd32;
      cfg.start_setting  <= 2'd0;
      cfg.check_interval <= 16'd1;
    end else if (write_enable) begin
      case (write_index)
        sopm_pkg::REG_AGENT_COUNT:    cfg.agent_count    <= write_data[6:0];
        sopm_pkg::REG_SPLIT_SIZE:     cfg.split_size     <= write_data[6:0];
        sopm_pkg::REG_START_SETTING:  cfg.start_setting  <= write_data[1:0];
        sopm_pkg::REG_CHECK_INTERVAL: cfg.check_interval <= write_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  sopm_mem #(
    .ROWS  (MAX_AGENTS),
    .WIDTH (MAX_AGENTS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sopm_seq #(
    .MAX_AGENTS (MAX_AGENTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_bal_checked: assert property (@(posedge clk) disable iff (rst)
    (done && result.balanced) |-> result.checked)
    else $error("balanced result without a check");

  a_unbal_none: assert property (@(posedge clk) disable iff (rst)
    (done && !result.balanced) |-> (result.outcome == sopm_pkg::OUT_NONE))
    else $error("outcome set on an unbalanced result");

endmodule
